// File: hdl/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg : shared types and constants for the shift-register FIFO
// Depth, derived widths, command and fill-state codes, and the control
// struct passed from the command logic to the entry store.
// ----------------------------------------------------------------------------
package srf_pkg;

  // Number of entries held (1 to 256)
  localparam int DEPTH = 16;

  // Width of a slot index and of the internal entry count
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Port field widths
  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int LOC_W   = 8;
  localparam int FILL_W  = 2;
  localparam int COUNT_W = 9;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FORCE_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP         = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_AT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_OLDEST = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PURGE       = 3'd5;

  // Fill-state codes
  localparam logic [FILL_W-1:0] FILL_EMPTY   = 2'd0;
  localparam logic [FILL_W-1:0] FILL_PARTIAL = 2'd1;
  localparam logic [FILL_W-1:0] FILL_FULL    = 2'd2;

  // Full count as an internal count value
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Registered command as it leaves the input stage
  typedef struct packed {
    logic                     valid;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    logic [LOC_W-1:0]         location;
  } srf_item_t;

  // Store control from the command logic
  typedef struct packed {
    logic                     push;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         rd_idx;
  } srf_store_ctl_t;

endpackage

// File: hdl/shift_register_fifo_top.sv
// ----------------------------------------------------------------------------
// shift_register_fifo_top : shift-register FIFO of signed milli-unit values
// Commands in, one result out per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a command (in_cmd, in_value, in_location) transfers at a rising
//   edge with start high and busy low. busy is high only while rst_n is low
//   and for the first cycle after, so one command can transfer every cycle.
//   Output: each command yields exactly one result, shown for one cycle with
//   out_valid high; the receiver cannot stall it and must take it then.
//   Timing: a command passes one input register and one result register; the
//   result strobe rises at the edge after the transfer edge. Throughput: one
//   command per cycle, set by the single pass from the input register through
//   the decode, the count update and the slot select into the result register.
//   Slot 0 is the newest entry; pushes shift all slots in parallel.
//   Reset empties the FIFO (count zero); slot contents are left as they are
//   and are never shown until written again.
// ----------------------------------------------------------------------------
module shift_register_fifo_top import srf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic signed [DATA_W-1:0]  in_value,
  input  logic [LOC_W-1:0]          in_location,
  output logic                      out_valid,
  output logic signed [DATA_W-1:0]  out_data,
  output logic                      out_ok,
  output logic [FILL_W-1:0]         out_fill_state,
  output logic [COUNT_W-1:0]        out_count
);

  srf_item_t                item;
  srf_store_ctl_t           ctl;
  logic signed [DATA_W-1:0] rd_data;

  srf_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_value    (in_value),
    .in_location (in_location),
    .item        (item)
  );

  srf_store u_store (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data)
  );

  srf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .rd_data        (rd_data),
    .ctl            (ctl),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .out_ok         (out_ok),
    .out_fill_state (out_fill_state),
    .out_count      (out_count)
  );

endmodule

// File: hdl/srf_in_reg.sv
// ----------------------------------------------------------------------------
// srf_in_reg : command input register
// Captures one command per transfer and raises busy while reset is applied.
// ----------------------------------------------------------------------------
module srf_in_reg import srf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [LOC_W-1:0]         in_location,
  output srf_item_t                item
);

  logic      busy_r;
  logic      valid_r;
  srf_item_t pay_r;

  assign busy = busy_r;

  // Hold off transfers while in reset, release on the first cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= start && !busy_r;
    end
  end

  // Capture the payload on each transfer
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      pay_r.cmd      <= in_cmd;
      pay_r.value    <= in_value;
      pay_r.location <= in_location;
    end
  end

  always_comb begin
    item.valid    = valid_r;
    item.cmd      = pay_r.cmd;
    item.value    = pay_r.value;
    item.location = pay_r.location;
  end

endmodule

// File: hdl/srf_store.sv
// ----------------------------------------------------------------------------
// srf_store : shift-register entry store
// Newest entry at slot 0; a push shifts every slot up by one in parallel,
// dropping whatever sat in the top slot. One read port selects a slot.
// ----------------------------------------------------------------------------
module srf_store import srf_pkg::*; (
  input  logic                     clk,
  input  srf_store_ctl_t           ctl,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] slot_r [DEPTH];

  // Shift in the new entry at slot 0
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slot_r[0] <= ctl.value;
      for (int i = 1; i < DEPTH; i++) begin
        slot_r[i] <= slot_r[i-1];
      end
    end
  end

  // Select the addressed slot
  assign rd_data = slot_r[ctl.rd_idx];

endmodule

// File: hdl/srf_ctrl.sv
// ----------------------------------------------------------------------------
// srf_ctrl : command decode, entry count and result register
// Decodes the registered command against the current count, drives the
// store and registers one result per command.
// ----------------------------------------------------------------------------
module srf_ctrl import srf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  srf_item_t                 item,
  input  logic signed [DATA_W-1:0]  rd_data,
  output srf_store_ctl_t            ctl,
  output logic                      out_valid,
  output logic signed [DATA_W-1:0]  out_data,
  output logic                      out_ok,
  output logic [FILL_W-1:0]         out_fill_state,
  output logic [COUNT_W-1:0]        out_count
);

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         last;
  logic [IDX_W-1:0]         loc_idx;
  logic                     not_full, not_empty;
  logic                     push;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     ok_nxt;
  logic [FILL_W-1:0]        fill_nxt;

  logic                     valid_r;
  logic signed [DATA_W-1:0] data_r;
  logic                     ok_r;
  logic [FILL_W-1:0]        fill_r;
  logic [CNT_W-1:0]         cnt_out_r;

  assign not_full  = (cnt_r < CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign last      = cnt_r - CNT_W'(1);

  // Clamp the read location to the oldest held slot
  always_comb begin
    if (COUNT_W'(item.location) > COUNT_W'(last)) begin
      loc_idx = last[IDX_W-1:0];
    end else begin
      loc_idx = item.location[IDX_W-1:0];
    end
  end

  // Decode the command
  always_comb begin
    cnt_nxt  = cnt_r;
    push     = 1'b0;
    data_nxt = '0;
    ok_nxt   = 1'b0;
    case (item.cmd)
      CMD_ADD: begin
        if (not_full) begin
          push    = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          ok_nxt  = 1'b1;
        end
      end
      CMD_FORCE_ADD: begin
        push   = 1'b1;
        ok_nxt = 1'b1;
        if (not_full) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (not_empty) begin
          cnt_nxt  = last;
          data_nxt = rd_data;
          ok_nxt   = 1'b1;
        end else begin
          data_nxt = '1;
        end
      end
      CMD_READ_AT, CMD_READ_OLDEST: begin
        if (not_empty) begin
          data_nxt = rd_data;
          ok_nxt   = 1'b1;
        end
      end
      CMD_PURGE: begin
        cnt_nxt = '0;
        ok_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Classify the count after the command
  always_comb begin
    if (cnt_nxt == '0) begin
      fill_nxt = FILL_EMPTY;
    end else if (cnt_nxt >= CNT_FULL) begin
      fill_nxt = FILL_FULL;
    end else begin
      fill_nxt = FILL_PARTIAL;
    end
  end

  // Drive the store
  always_comb begin
    ctl.push   = push && item.valid;
    ctl.value  = item.value;
    ctl.rd_idx = (item.cmd == CMD_READ_AT) ? loc_idx : last[IDX_W-1:0];
  end

  // Advance the count and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= item.valid;
      if (item.valid) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (item.valid) begin
      data_r    <= data_nxt;
      ok_r      <= ok_nxt;
      fill_r    <= fill_nxt;
      cnt_out_r <= cnt_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_data       = data_r;
  assign out_ok         = ok_r;
  assign out_fill_state = fill_r;
  assign out_count      = COUNT_W'(cnt_out_r);

endmodule

// File: hdl/srf_checker.sv
// ----------------------------------------------------------------------------
// srf_checker : port-level checks for the shift-register FIFO
// Watches transfer-to-result timing, the fill state against the count, the count bound and known status fields.
// ----------------------------------------------------------------------------
module srf_checker import srf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic               out_ok,
  input logic [FILL_W-1:0]  out_fill_state,
  input logic [COUNT_W-1:0] out_count
);

  // Every transfer yields a result once it has passed the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("transfer not followed by a result");

  // No result without a matching transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a transfer");

  // Fill state agrees with the count
  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_count == '0) == (out_fill_state == FILL_EMPTY)) &&
                  ((out_count == COUNT_W'(DEPTH)) == (out_fill_state == FILL_FULL)))
    else $error("fill state disagrees with count");

  // Count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= COUNT_W'(DEPTH)))
    else $error("count beyond depth");

  // Status fields are known whenever a result is shown
  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_ok, out_fill_state, out_count}))
    else $error("unknown status on a result");

endmodule

bind shift_register_fifo_top srf_checker u_srf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_ok         (out_ok),
  .out_fill_state (out_fill_state),
  .out_count      (out_count)
);

// File: bench/shift_register_fifo_top_test.sv
// ----------------------------------------------------------------------------
// shift_register_fifo_top_test : command and result check of the FIFO
// Drives add, force add, pop, read, read-oldest, purge and spare commands through
// the start/busy handshake with random gaps. A mirror of the FIFO contents
// predicts every result; each out_valid strobe is checked field by field
// against the oldest prediction. A directed opening covers the empty and
// full corners, then random traffic swings between filling and draining.
// ----------------------------------------------------------------------------
module shift_register_fifo_top_test import srf_pkg::*; ();

  // Spare command codes, taken but with no effect
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 1425;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_PRINTED  = 40;

  // Mode of the random traffic
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic                     ok;
    logic [FILL_W-1:0]        fill;
    logic [COUNT_W-1:0]       count;
  } fifo_result_t;

  // Mirror of the FIFO contents and the queue of predicted results
  class fifo_mirror;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned              held;
    fifo_result_t             pending_results [$];
    int unsigned              mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function logic [FILL_W-1:0] fill_of(int unsigned n);
      if (n == 0) return FILL_EMPTY;
      if (n >= DEPTH) return FILL_FULL;
      return FILL_PARTIAL;
    endfunction

    // Shift held entries up one slot; the oldest drops off when full
    function void push_front(logic signed [DATA_W-1:0] v);
      int top;
      top = (held > DEPTH - 1) ? DEPTH - 1 : held;
      for (int i = top; i > 0; i--) slots[i] = slots[i-1];
      slots[0] = v;
      if (held < DEPTH) held++;
    endfunction

    // Predict the result of one accepted command
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
                               logic [LOC_W-1:0] loc);
      fifo_result_t r;
      int unsigned  slot;
      r.data = '0;
      r.ok   = 1'b0;
      case (cmd)
        CMD_ADD: begin
          if (held < DEPTH) begin
            push_front(val);
            r.ok = 1'b1;
          end
        end
        CMD_FORCE_ADD: begin
          push_front(val);
          r.ok = 1'b1;
        end
        CMD_POP: begin
          if (held > 0) begin
            held--;
            r.data = slots[held];
            r.ok   = 1'b1;
          end else begin
            r.data = -1;
          end
        end
        CMD_READ_AT: begin
          if (held > 0) begin
            slot   = (loc > held - 1) ? held - 1 : loc;
            r.data = slots[slot];
            r.ok   = 1'b1;
          end
        end
        CMD_READ_OLDEST: begin
          if (held > 0) begin
            r.data = slots[held-1];
            r.ok   = 1'b1;
          end
        end
        CMD_PURGE: begin
          held = 0;
          r.ok = 1'b1;
        end
        default: begin
        end
      endcase
      r.fill  = fill_of(held);
      r.count = COUNT_W'(held);
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    // Compare one strobed result with the oldest prediction
    task check_result(logic signed [DATA_W-1:0] data, logic ok, logic [FILL_W-1:0] fill,
                      logic [COUNT_W-1:0] count);
      fifo_result_t e;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending, data %0d count %0d",
                                  data, count));
        return;
      end
      e = pending_results.pop_front();
      if (data !== e.data)
        report_mismatch($sformatf("data %0d, predicted %0d", data, e.data));
      if (ok !== e.ok)
        report_mismatch($sformatf("ok %0b, predicted %0b", ok, e.ok));
      if (fill !== e.fill)
        report_mismatch($sformatf("fill state %0d, predicted %0d", fill, e.fill));
      if (count !== e.count)
        report_mismatch($sformatf("count %0d, predicted %0d", count, e.count));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         in_cmd = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [LOC_W-1:0]         in_location = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_ok;
  logic [FILL_W-1:0]        out_fill_state;
  logic [COUNT_W-1:0]       out_count;

  int unsigned cycle_count = 0;
  fifo_mirror  mirror = new();

  shift_register_fifo_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .in_location    (in_location),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .out_ok         (out_ok),
    .out_fill_state (out_fill_state),
    .out_count      (out_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      mirror.check_result(out_data, out_ok, out_fill_state, out_count);
  end

  // Hold off for the gap, offer the command, then wait for its transfer
  task send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
                    logic [LOC_W-1:0] loc, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_cmd      <= cmd;
    in_value    <= val;
    in_location <= loc;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.note_command(cmd, val, loc);
  endtask

  function logic [CMD_W-1:0] pick_cmd(int mode);
    int w;
    w = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (w < 50) return CMD_ADD;
        if (w < 65) return CMD_FORCE_ADD;
        if (w < 73) return CMD_POP;
        if (w < 85) return CMD_READ_AT;
        if (w < 95) return CMD_READ_OLDEST;
        if (w < 97) return CMD_PURGE;
      end
      MODE_DRAIN: begin
        if (w < 12) return CMD_ADD;
        if (w < 20) return CMD_FORCE_ADD;
        if (w < 60) return CMD_POP;
        if (w < 75) return CMD_READ_AT;
        if (w < 90) return CMD_READ_OLDEST;
        if (w < 95) return CMD_PURGE;
      end
      default: begin
        if (w < 30) return CMD_ADD;
        if (w < 45) return CMD_FORCE_ADD;
        if (w < 70) return CMD_POP;
        if (w < 85) return CMD_READ_AT;
        if (w < 95) return CMD_READ_OLDEST;
        if (w < 97) return CMD_PURGE;
      end
    endcase
    return ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
  endfunction

  // Mostly full-width random values, with the extremes now and then
  function logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -1;
      4:       return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // Favour locations near the held range so clamping and exact hits both occur
  function logic [LOC_W-1:0] pick_location();
    if ($urandom_range(0, 9) < 6) return LOC_W'($urandom_range(0, DEPTH + 1));
    return LOC_W'($urandom_range(0, 255));
  endfunction

  // Cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic signed [DATA_W-1:0] val;
    int                       mode;
    int                       mode_left;
    bit                       quiet;

    mode      = MODE_MIXED;
    mode_left = 0;
    quiet     = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty corners: pop, read and read-oldest of an empty FIFO, spare codes
    send_command(CMD_POP, '0, '0, $urandom_range(0, 11));
    send_command(CMD_READ_AT, '0, 8'd255, $urandom_range(0, 11));
    send_command(CMD_READ_OLDEST, '0, '0, $urandom_range(0, 11));
    send_command(CMD_SPARE_A, 32'sh7fffffff, 8'd255, 0);
    send_command(CMD_SPARE_B, 32'sh80000000, '0, 0);

    // Fill to full, starting with extreme values, then try one add too many
    for (int i = 0; i < DEPTH + 1; i++) begin
      case (i)
        0:       val = 32'sh7fffffff;
        1:       val = 32'sh80000000;
        2:       val = '0;
        3:       val = -1;
        default: val = $urandom;
      endcase
      send_command(CMD_ADD, val, '0, (i < 8) ? 0 : $urandom_range(0, 11));
    end

    // Full corners: overwrite, clamped and exact reads, read-oldest, pop, purge
    send_command(CMD_FORCE_ADD, 32'sh55aa55aa, '0, 0);
    send_command(CMD_READ_AT, '0, 8'd255, 0);
    send_command(CMD_READ_AT, '0, '0, $urandom_range(0, 11));
    send_command(CMD_READ_OLDEST, '0, '0, 0);
    send_command(CMD_POP, '0, '0, 0);
    send_command(CMD_PURGE, '0, '0, $urandom_range(0, 11));

    // Random traffic that swings between filling and draining
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(MODE_FILL, MODE_MIXED);
        mode_left = $urandom_range(20, 80);
        quiet     = ($urandom_range(0, 3) == 0);
      end
      mode_left--;
      send_command(pick_cmd(mode), pick_value(), pick_location(),
                   quiet ? 0 : $urandom_range(0, 11));
    end
    start <= 1'b0;

    // Drain the outstanding results
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.mismatches == 0 && mirror.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/srf_pkg.sv
hdl/srf_in_reg.sv
hdl/srf_store.sv
hdl/srf_ctrl.sv
hdl/shift_register_fifo_top.sv
hdl/srf_checker.sv
bench/shift_register_fifo_top_test.sv
